// ----- rtl/opph_pkg.sv -----
// opph_pkg: shared types and constants of the OpenPGP packet header parser.
// No dependencies; referenced by every other file of the block.
package opph_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned TYPE_W          = 6;
    localparam int unsigned ERR_W           = 2;
    localparam int unsigned ACC_W           = 32;
    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH     = 4;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TAG   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd2;

    localparam logic [BYTE_W-1:0] LEN1_MAX  = 8'd191;
    localparam logic [BYTE_W-1:0] LEN2_MAX  = 8'd223;
    localparam logic [BYTE_W-1:0] LEN5_MARK = 8'd255;
    localparam logic [BYTE_W-1:0] LEN2_BASE = 8'd192;
    localparam logic [1:0]        OLD_INDEF = 2'd3;

    typedef enum logic [5:0] {
        PH_TAG    = 6'b000001,
        PH_NEWLEN = 6'b000010,
        PH_MORELEN= 6'b000100,
        PH_BODY   = 6'b001000,
        PH_INDEF  = 6'b010000,
        PH_DRAIN  = 6'b100000
    } t_phase;

    // front-to-back command: optional type load plus optional result
    typedef struct packed {
        logic              load_type;
        logic [TYPE_W-1:0] new_type;
        logic              emit;
        logic              has_payload;
        logic [BYTE_W-1:0] payload_byte;
        logic              packet_end;
        logic [ERR_W-1:0]  error_code;
    } t_cmd;

endpackage

// ----- rtl/opph_in_if.sv -----
// opph_in_if: input byte channel (valid/ready plus one stream byte).
// Depends on opph_pkg.
interface opph_in_if;
    logic                        valid;
    logic                        ready;
    logic [opph_pkg::BYTE_W-1:0] in_byte;
    logic                        end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ----- rtl/opph_out_if.sv -----
// opph_out_if: result channel (valid/ready plus one decoded result).
// Depends on opph_pkg.
interface opph_out_if;
    logic                        valid;
    logic                        ready;
    logic                        has_payload;
    logic [opph_pkg::BYTE_W-1:0] payload_byte;
    logic [opph_pkg::TYPE_W-1:0] packet_type;
    logic                        packet_end;
    logic [opph_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output has_payload, output payload_byte,
                    output packet_type, output packet_end, output error_code,
                    input ready);
    modport sink   (input valid, input has_payload, input payload_byte,
                    input packet_type, input packet_end, input error_code,
                    output ready);
endinterface

// ----- rtl/openpgp_packet_header_parser_unit.sv -----
// openpgp_packet_header_parser_unit: top level of the OpenPGP packet header parser.
// Depends on opph_pkg, opph_in_if, opph_out_if, opph_front, opph_fifo, opph_back.
//
// Usage:
//   i_in carries one stream byte per request with end_of_input on the last byte
//   of a buffer. o_out carries at most one result per input byte: a body byte
//   with its packet type, an end mark of an empty packet, or an error code.
//   Header bytes that end no packet, and bytes dropped after a bad tag, give
//   no result.
//   Throughput: one input byte per cycle while the command queue is not full; the
//   header decoder updates its phase and length counter once per accepted byte.
//   Path: a result is written into the queue at the edge that accepts its byte,
//   then moves into the output register once that register is free or taken.
//   Stall: a four-entry command queue sits between decoder and output register;
//   i_in.ready drops only while that queue is full.
//   Reset (i_rst_n low, synchronous): the decoder expects a tag byte, the queue
//   and the output register are empty.
module openpgp_packet_header_parser_unit #(
    parameter int unsigned LENGTH_BITS = opph_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    opph_in_if.sink     i_in,
    opph_out_if.source  o_out
);
    import opph_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    opph_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    opph_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .o_valid(q_valid),
        .o_cmd  (head_cmd),
        .i_pop  (pop)
    );

    opph_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_cmd  (head_cmd),
        .o_pop  (pop),
        .o_out  (o_out)
    );

endmodule

// ----- rtl/opph_front.sv -----
// opph_front: header decoder; tracks framing phase and lengths per byte
// and emits commands into the queue. Depends on opph_pkg, opph_in_if.
module opph_front #(
    parameter int unsigned LENGTH_BITS = opph_pkg::LENGTH_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    opph_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output opph_pkg::t_cmd  o_cmd
);
    import opph_pkg::*;

    localparam logic [ACC_W-1:0] LEN_MAX = ACC_W'({ACC_W{1'b1}} >> (ACC_W - LENGTH_BITS));

    t_phase                 r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [2:0]             r_len_left, n_len_left;
    logic                   r_partial, n_partial;
    logic                   r_two, n_two;
    logic [4:0]             r_first_lo, n_first_lo;

    logic                   accept;
    logic [BYTE_W-1:0]      b;
    logic                   fin;
    logic [ACC_W-1:0]       fin_len;
    logic [ACC_W-1:0]       sat_len;
    logic [ACC_W-1:0]       acc_shift;
    t_cmd                   cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign acc_shift  = {r_acc[ACC_W-BYTE_W-1:0], b};

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_len_left  = r_len_left;
        n_partial   = r_partial;
        n_two       = r_two;
        n_first_lo  = r_first_lo;
        cmd         = '0;
        fin         = 1'b0;
        fin_len     = '0;
        sat_len     = '0;

        case (r_phase)
            PH_TAG: begin
                n_partial = 1'b0;
                cmd.load_type = 1'b1;
                if (!b[7]) begin
                    cmd.new_type   = '0;
                    cmd.emit       = 1'b1;
                    cmd.error_code = ERR_TAG;
                    n_phase        = PH_DRAIN;
                end else if (b[6]) begin
                    cmd.new_type = b[5:0];
                    n_phase      = PH_NEWLEN;
                end else begin
                    cmd.new_type = {2'b00, b[5:2]};
                    if (b[1:0] == OLD_INDEF) begin
                        n_phase = PH_INDEF;
                    end else begin
                        n_acc      = '0;
                        n_two      = 1'b0;
                        n_len_left = 3'd1 << b[1:0];
                        n_phase    = PH_MORELEN;
                    end
                end
            end
            PH_NEWLEN: begin
                n_first_lo = b[4:0];
                if (b <= LEN1_MAX) begin
                    n_partial = 1'b0;
                    fin       = 1'b1;
                    fin_len   = ACC_W'(b);
                end else if (b <= LEN2_MAX) begin
                    n_partial = 1'b0;
                    n_two     = 1'b1;
                    n_phase   = PH_MORELEN;
                end else if (b == LEN5_MARK) begin
                    n_partial  = 1'b0;
                    n_two      = 1'b0;
                    n_acc      = '0;
                    n_len_left = 3'd4;
                    n_phase    = PH_MORELEN;
                end else begin
                    n_partial = 1'b1;
                    fin       = 1'b1;
                    fin_len   = ACC_W'(1) << b[4:0];
                end
            end
            PH_MORELEN: begin
                if (r_two) begin
                    fin     = 1'b1;
                    fin_len = ACC_W'({r_first_lo, b}) + ACC_W'(LEN2_BASE);
                end else begin
                    n_acc      = acc_shift;
                    n_len_left = r_len_left - 3'd1;
                    if (r_len_left == 3'd1) begin
                        fin     = 1'b1;
                        fin_len = acc_shift;
                    end
                end
            end
            PH_BODY: begin
                n_remaining      = r_remaining - LENGTH_BITS'(1);
                cmd.emit         = 1'b1;
                cmd.has_payload  = 1'b1;
                cmd.payload_byte = b;
                if (r_remaining == LENGTH_BITS'(1)) begin
                    if (r_partial) begin
                        n_phase = PH_NEWLEN;
                    end else begin
                        cmd.packet_end = 1'b1;
                        n_phase        = PH_TAG;
                    end
                end
            end
            PH_INDEF: begin
                cmd.emit         = 1'b1;
                cmd.has_payload  = 1'b1;
                cmd.payload_byte = b;
            end
            PH_DRAIN: begin
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        if (fin) begin
            sat_len     = (fin_len > LEN_MAX) ? LEN_MAX : fin_len;
            n_remaining = sat_len[LENGTH_BITS-1:0];
            if (sat_len == '0) begin
                n_phase        = PH_TAG;
                n_partial      = 1'b0;
                cmd.emit       = 1'b1;
                cmd.packet_end = 1'b1;
            end else begin
                n_phase = PH_BODY;
            end
        end

        if (i_in.end_of_input) begin
            if (n_phase == PH_INDEF) begin
                cmd.emit       = 1'b1;
                cmd.packet_end = 1'b1;
            end else if (n_phase == PH_NEWLEN || n_phase == PH_MORELEN
                         || n_phase == PH_BODY) begin
                cmd.emit       = 1'b1;
                cmd.packet_end = 1'b0;
                cmd.error_code = ERR_TRUNC;
            end
            n_phase   = PH_TAG;
            n_partial = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.load_type || cmd.emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_partial  <= 1'b0;
            r_len_left <= '0;
            r_two      <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_partial  <= n_partial;
            r_len_left <= n_len_left;
            r_two      <= n_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_first_lo  <= n_first_lo;
        end
    end

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_remaining != '0))
        else $error("body phase with zero byte count");

    a_len_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MORELEN && !r_two) |-> (r_len_left != 3'd0 && r_len_left <= 3'd4))
        else $error("length octet count out of range");

endmodule

// ----- rtl/opph_fifo.sv -----
// opph_fifo: short command queue between header decoder and result stage.
// Depends on opph_pkg.
module opph_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  opph_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output opph_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import opph_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue underflow");

endmodule

// ----- rtl/opph_back.sv -----
// opph_back: result stage; holds the current packet type and the output
// register. Depends on opph_pkg, opph_out_if.
module opph_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  opph_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    opph_out_if.source      o_out
);
    import opph_pkg::*;

    logic              r_valid;
    logic [TYPE_W-1:0] r_type;
    logic              r_has_payload;
    logic [BYTE_W-1:0] r_payload_byte;
    logic [TYPE_W-1:0] r_packet_type;
    logic              r_packet_end;
    logic [ERR_W-1:0]  r_error_code;
    logic [TYPE_W-1:0] cur_type;

    assign o_pop    = i_valid && (!r_valid || o_out.ready);
    assign cur_type = i_cmd.load_type ? i_cmd.new_type : r_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_type  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= i_cmd.emit;
                r_type  <= cur_type;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.emit) begin
            r_has_payload  <= i_cmd.has_payload;
            r_payload_byte <= i_cmd.payload_byte;
            r_packet_type  <= cur_type;
            r_packet_end   <= i_cmd.packet_end;
            r_error_code   <= i_cmd.error_code;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.has_payload  = r_has_payload;
    assign o_out.payload_byte = r_payload_byte;
    assign o_out.packet_type  = r_packet_type;
    assign o_out.packet_end   = r_packet_end;
    assign o_out.error_code   = r_error_code;

    a_tag_err_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code == ERR_TAG) |-> (o_out.packet_type == '0
            && !o_out.has_payload && !o_out.packet_end))
        else $error("bad-tag result carries packet data");

endmodule

// ----- bench/openpgp_packet_header_parser_unit_tb.sv -----
// Testbench of openpgp_packet_header_parser_unit: a byte stream of OpenPGP packets
// checked result by result against a cycle-free predictor of the header parser.
// Depends on opph_pkg, opph_in_if, opph_out_if and the RTL of the block.
`timescale 1ns / 100ps

module openpgp_packet_header_parser_unit_tb;
    import opph_pkg::*;

    typedef struct packed {
        logic              has_payload;
        logic [BYTE_W-1:0] payload_byte;
        logic [TYPE_W-1:0] packet_type;
        logic              packet_end;
        logic [ERR_W-1:0]  error_code;
    } t_pkt_result;

    // fixed: the row carries a hand-written result in want
    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              eoi;
        bit                fixed;
        t_pkt_result       want;
    } t_stream_byte;

    localparam logic [31:0] LEN_CAP = 32'hFFFF_FFFF >> (32 - LENGTH_BITS_DEF);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    opph_in_if  in_if ();
    opph_out_if out_if ();

    openpgp_packet_header_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_stream_byte byte_stream[$];
    t_pkt_result  pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          in_fired = 1'b0;
    int unsigned fail_cnt = 0;
    int unsigned bytes_in = 0;
    int unsigned results_seen = 0;
    int unsigned ends_seen = 0;
    int unsigned errs_seen = 0;

    // parser state of the predictor
    t_phase            prs_phase = PH_TAG;
    logic [TYPE_W-1:0] cur_type = '0;
    logic [31:0]       body_left = '0;
    logic [2:0]        octets_left = '0;
    logic              in_partial = 1'b0;
    logic [BYTE_W-1:0] len_lead = '0;

    t_stream_byte opening_rows [25] = '{
        '{8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0, ERR_TAG}},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h3F, 1'b1, 1'b1, '{1'b0, 8'h00, 6'd0, 1'b0, ERR_TAG}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 6'd63, 1'b1, ERR_NONE}},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'hDF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 6'd2, 1'b0, ERR_TRUNC}},
        '{8'hC3, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{1'b0, 8'h00, 6'd3, 1'b0, ERR_TRUNC}},
        '{8'hC5, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'h11, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h22, 1'b0, 1'b0, '0},
        '{8'h8F, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'h66, 1'b1, 1'b0, '0},
        '{8'h8F, 1'b1, 1'b1, '{1'b0, 8'h00, 6'd3, 1'b1, ERR_NONE}},
        '{8'hC6, 1'b1, 1'b1, '{1'b0, 8'h00, 6'd6, 1'b0, ERR_TRUNC}},
        '{8'h84, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 6'd1, 1'b1, ERR_NONE}}
    };

    function automatic t_pkt_result make_result(input logic hp, input logic [BYTE_W-1:0] pb,
                                                input logic pe, input logic [ERR_W-1:0] ec);
        return '{hp, pb, cur_type, pe, ec};
    endfunction

    function automatic bit close_length(input logic [31:0] len, output t_pkt_result r);
        logic [31:0] n;
        n = (len > LEN_CAP) ? LEN_CAP : len;
        body_left = n;
        octets_left = '0;
        r = '0;
        if (n == 0) begin
            prs_phase = PH_TAG;
            in_partial = 1'b0;
            r = make_result(1'b0, 8'h00, 1'b1, ERR_NONE);
            return 1'b1;
        end
        prs_phase = PH_BODY;
        return 1'b0;
    endfunction

    function automatic bit frame_byte(input logic [BYTE_W-1:0] b, input logic eoi,
                                      output t_pkt_result r);
        bit made;
        made = 1'b0;
        r = '0;
        case (prs_phase)
            PH_TAG: begin
                in_partial = 1'b0;
                body_left = '0;
                if (!b[7]) begin
                    cur_type = '0;
                    r = make_result(1'b0, 8'h00, 1'b0, ERR_TAG);
                    made = 1'b1;
                    prs_phase = PH_DRAIN;
                end else if (b[6]) begin
                    cur_type = b[5:0];
                    prs_phase = PH_NEWLEN;
                end else begin
                    cur_type = {2'b00, b[5:2]};
                    if (b[1:0] == OLD_INDEF) begin
                        prs_phase = PH_INDEF;
                    end else begin
                        len_lead = '0;
                        octets_left = 3'd1 << b[1:0];
                        prs_phase = PH_MORELEN;
                    end
                end
            end
            PH_NEWLEN: begin
                len_lead = b;
                if (b <= LEN1_MAX) begin
                    in_partial = 1'b0;
                    made = close_length({24'd0, b}, r);
                end else if (b <= LEN2_MAX) begin
                    in_partial = 1'b0;
                    octets_left = 3'd1;
                    prs_phase = PH_MORELEN;
                end else if (b == LEN5_MARK) begin
                    in_partial = 1'b0;
                    body_left = '0;
                    octets_left = 3'd4;
                    prs_phase = PH_MORELEN;
                end else begin
                    in_partial = 1'b1;
                    made = close_length(32'd1 << b[4:0], r);
                end
            end
            PH_MORELEN: begin
                if (len_lead >= LEN2_BASE && len_lead <= LEN2_MAX) begin
                    made = close_length({16'd0, len_lead - LEN2_BASE, b} + 32'(LEN2_BASE), r);
                end else begin
                    body_left = (body_left << 8) | {24'd0, b};
                    octets_left = octets_left - 3'd1;
                    if (octets_left == 0) made = close_length(body_left, r);
                end
            end
            PH_BODY: begin
                body_left = body_left - 32'd1;
                made = 1'b1;
                if (body_left == 0 && !in_partial) begin
                    r = make_result(1'b1, b, 1'b1, ERR_NONE);
                    prs_phase = PH_TAG;
                end else begin
                    r = make_result(1'b1, b, 1'b0, ERR_NONE);
                    if (body_left == 0) prs_phase = PH_NEWLEN;
                end
            end
            PH_INDEF: begin
                r = make_result(1'b1, b, 1'b0, ERR_NONE);
                made = 1'b1;
            end
            default: ;
        endcase
        if (eoi) begin
            if (prs_phase == PH_INDEF) begin
                if (!made) r = make_result(1'b0, 8'h00, 1'b1, ERR_NONE);
                else r.packet_end = 1'b1;
                made = 1'b1;
            end else if (prs_phase inside {PH_NEWLEN, PH_MORELEN, PH_BODY}) begin
                if (!made) begin
                    r = make_result(1'b0, 8'h00, 1'b0, ERR_TRUNC);
                end else begin
                    r.packet_end = 1'b0;
                    r.error_code = ERR_TRUNC;
                end
                made = 1'b1;
            end
            prs_phase = PH_TAG;
            in_partial = 1'b0;
            body_left = '0;
            octets_left = '0;
        end
        return made;
    endfunction

    // one packet, possibly cut short by the end mark; sizes kept small
    task automatic add_packet();
        logic [BYTE_W-1:0] pkt[$];
        logic [31:0]       len;
        int unsigned       kind, nbody, stop, lt, roll;
        bit                cut, close_at_end, mark;
        cut = 1'b0;
        close_at_end = 1'b0;
        nbody = 0;
        kind = $urandom_range(99);
        if (kind < 8) begin
            pkt.push_back({1'b0, 7'($urandom)});
            repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
            close_at_end = 1'b1;
        end else if (kind < 30) begin
            pkt.push_back({2'b11, 6'($urandom)});
            nbody = ($urandom_range(99) < 4) ? $urandom_range(191, 16) : $urandom_range(15);
            pkt.push_back(8'(nbody));
        end else if (kind < 40) begin
            pkt.push_back({2'b11, 6'($urandom)});
            if ($urandom_range(99) < 5) begin
                len = $urandom_range(10);
                pkt.push_back(LEN2_BASE);
                pkt.push_back(8'(len));
                nbody = 192 + len;
            end else begin
                pkt.push_back(8'($urandom_range(223, 192)));
                pkt.push_back(8'($urandom));
                nbody = $urandom_range(6, 1);
                cut = 1'b1;
            end
        end else if (kind < 55) begin
            pkt.push_back({2'b11, 6'($urandom)});
            pkt.push_back(LEN5_MARK);
            roll = $urandom_range(99);
            len = (roll < 65) ? $urandom_range(15) : (roll < 75) ? 32'hFFFF_FFFF : $urandom;
            for (int i = 3; i >= 0; i--) pkt.push_back(len[8*i +: 8]);
            cut = (len > 15);
            nbody = cut ? $urandom_range(6, 1) : len;
        end else if (kind < 70) begin
            pkt.push_back({2'b11, 6'($urandom)});
            repeat ($urandom_range(3, 1)) begin
                lt = $urandom_range(4);
                pkt.push_back(8'(224 + lt));
                repeat (1 << lt) pkt.push_back(8'($urandom));
            end
            roll = $urandom_range(99);
            if (roll < 70) begin
                nbody = $urandom_range(10);
                pkt.push_back(8'(nbody));
            end else if (roll < 85) begin
                nbody = $urandom_range(10);
                pkt.push_back(LEN5_MARK);
                repeat (3) pkt.push_back(8'h00);
                pkt.push_back(8'(nbody));
            end else begin
                pkt.push_back(8'($urandom_range(223, 192)));
                pkt.push_back(8'($urandom));
                nbody = $urandom_range(4, 1);
                cut = 1'b1;
            end
        end else if (kind < 88) begin
            lt = $urandom_range(2);
            pkt.push_back({2'b10, 4'($urandom), 2'(lt)});
            len = ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom;
            len = len & (32'hFFFF_FFFF >> (32 - 8 * (1 << lt)));
            for (int i = (1 << lt) - 1; i >= 0; i--) pkt.push_back(len[8*i +: 8]);
            cut = (len > 15);
            nbody = cut ? $urandom_range(6, 1) : len;
        end else begin
            pkt.push_back({2'b10, 4'($urandom), OLD_INDEF});
            nbody = $urandom_range(8);
            close_at_end = 1'b1;
        end
        repeat (nbody) pkt.push_back(8'($urandom));

        roll = $urandom_range(99);
        stop = pkt.size() - 1;
        mark = 1'b1;
        if (cut || (!close_at_end && roll < 10)) stop = $urandom_range(pkt.size() - 1);
        else if (!close_at_end && roll >= 35) mark = 1'b0;
        for (int i = 0; i <= stop; i++)
            byte_stream.push_back('{pkt[i], mark && (i == stop), 1'b0, '0});
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("openpgp_packet_header_parser_unit verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fired) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_if.valid <= 1'b1;
                in_if.in_byte <= byte_stream[0].b;
                in_if.end_of_input <= byte_stream[0].eoi;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        in_fired = 1'b0;
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : watch
        t_stream_byte sb;
        t_pkt_result  r, got;
        bit           made;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb = byte_stream.pop_front();
                made = frame_byte(sb.b, sb.eoi, r);
                if (sb.fixed) begin
                    r = sb.want;
                    made = 1'b1;
                end
                if (made) pending_results.push_back(r);
                bytes_in++;
                in_fired = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.has_payload, out_if.payload_byte, out_if.packet_type,
                        out_if.packet_end, out_if.error_code};
                results_seen++;
                if (got.packet_end) ends_seen++;
                if (got.error_code != ERR_NONE) errs_seen++;
                if (pending_results.size() == 0) begin
                    $error("result with none expected: payload 0x%0h type %0d end %0d err %0d",
                           got.payload_byte, got.packet_type, got.packet_end, got.error_code);
                    fail_cnt++;
                end else begin
                    r = pending_results.pop_front();
                    check_field("has_payload", 32'(r.has_payload), 32'(got.has_payload));
                    check_field("payload_byte", 32'(r.payload_byte), 32'(got.payload_byte));
                    check_field("packet_type", 32'(r.packet_type), 32'(got.packet_type));
                    check_field("packet_end", 32'(r.packet_end), 32'(got.packet_end));
                    check_field("error_code", 32'(r.error_code), 32'(got.error_code));
                end
            end
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        in_if.end_of_input = 1'b0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[i]) byte_stream.push_back(opening_rows[i]);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            while (byte_stream.size() < 115) add_packet();
            while (byte_stream.size() != 0) @(posedge i_clk);
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("%0d stream bytes sent under four idle/stall mixes, %0d results checked",
                 bytes_in, results_seen);
        $display("%0d packet ends and %0d error results seen, %0d mismatches",
                 ends_seen, errs_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("openpgp_packet_header_parser_unit verification clean");
        end else begin
            $display("openpgp_packet_header_parser_unit verification failed");
        end
        $finish;
    end

endmodule
